### hdl/hpa_pkg.sv
// ----------------------------------------------------------------------------
// hpa_pkg
// shared types, codes and sizes for the handle pool allocator
// ----------------------------------------------------------------------------
package hpa_pkg;

	// pool geometry
	localparam int POOL_SIZE = 16;
	localparam int PTR_W     = $clog2(POOL_SIZE);
	localparam int CNT_W     = $clog2(POOL_SIZE + 1);

	// field widths
	localparam int CMD_W    = 2;
	localparam int HANDLE_W = 4;
	localparam int STATUS_W = 2;

	// command codes
	localparam logic [CMD_W-1:0] CMD_ALLOCATE     = 2'd0;
	localparam logic [CMD_W-1:0] CMD_TRY_ALLOCATE = 2'd1;
	localparam logic [CMD_W-1:0] CMD_DEALLOCATE   = 2'd2;

	// status codes
	localparam logic [STATUS_W-1:0] ST_OK            = 2'd0;
	localparam logic [STATUS_W-1:0] ST_NONE_TO_REUSE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_NOT_ALLOCATED = 2'd2;
	localparam logic [STATUS_W-1:0] ST_EXHAUSTED     = 2'd3;

	typedef struct packed {
		logic [CMD_W-1:0]    command;
		logic [HANDLE_W-1:0] release_handle;
	} req_t;

	typedef struct packed {
		logic [HANDLE_W-1:0] granted_handle;
		logic [STATUS_W-1:0] status;
	} rsp_t;

	// controller to datapath
	typedef struct packed {
		logic load;
		logic exec;
	} ctl_t;

	typedef enum logic {
		ST_IDLE,
		ST_EXEC
	} state_t;

endpackage

### hdl/hpa_ram.sv
// ----------------------------------------------------------------------------
// hpa_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module hpa_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_q <= mem_q[raddr];
	end

	assign rdata = rdata_q;

endmodule

### hdl/hpa_ctrl.sv
// ----------------------------------------------------------------------------
// hpa_ctrl
// request sequencer: accept, then execute, then result strobe
// ----------------------------------------------------------------------------
module hpa_ctrl
	import hpa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	output logic done,
	output ctl_t ctl
);

	state_t state_q, state_d;
	logic   done_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			done_q  <= 1'b0;
		end else begin
			state_q <= state_d;
			done_q  <= ctl.exec;
		end
	end

	always_comb begin
		state_d  = state_q;
		ctl.load = 1'b0;
		ctl.exec = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (start) begin
					ctl.load = 1'b1;
					state_d  = ST_EXEC;
				end
			end
			ST_EXEC: begin
				ctl.exec = 1'b1;
				state_d  = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	assign busy = (state_q != ST_IDLE);
	assign done = done_q;

endmodule

### hdl/hpa_dp.sv
// ----------------------------------------------------------------------------
// hpa_dp
// allocator datapath: free queue, allocation bitmap, fresh counter, result
// ----------------------------------------------------------------------------
module hpa_dp
	import hpa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  ctl_t ctl,
	input  req_t req,
	output rsp_t rsp
);

	req_t                 req_q;
	rsp_t                 rsp_q;
	logic [PTR_W-1:0]     head_q, tail_q;
	logic [CNT_W-1:0]     count_q, fresh_q;
	logic [POOL_SIZE-1:0] marks_q;

	logic [HANDLE_W-1:0]  rd_data;
	logic                 q_empty;
	logic                 rel_ok;
	logic [PTR_W-1:0]     rel_idx;
	logic [PTR_W-1:0]     head_nxt, tail_nxt;

	// next state of the datapath for the current request
	logic                 pop, push, take_fresh;
	rsp_t                 res;

	hpa_ram #(
		.WIDTH(HANDLE_W),
		.DEPTH(POOL_SIZE)
	) u_free_queue (
		.clk  (clk),
		.we   (push),
		.waddr(tail_q),
		.wdata(req_q.release_handle),
		.raddr(head_q),
		.rdata(rd_data)
	);

	assign q_empty  = (count_q == '0);
	assign rel_idx  = PTR_W'(req_q.release_handle);
	assign rel_ok   = (32'(req_q.release_handle) < POOL_SIZE) && marks_q[rel_idx]
		&& (32'(count_q) < POOL_SIZE);
	assign head_nxt = (32'(head_q) == POOL_SIZE - 1) ? '0 : head_q + 1'b1;
	assign tail_nxt = (32'(tail_q) == POOL_SIZE - 1) ? '0 : tail_q + 1'b1;

	always_comb begin
		pop        = 1'b0;
		push       = 1'b0;
		take_fresh = 1'b0;
		res.granted_handle = '0;
		res.status         = ST_OK;
		unique case (req_q.command)
			CMD_ALLOCATE: begin
				if (!q_empty) begin
					pop = ctl.exec;
					res.granted_handle = rd_data;
				end else if (32'(fresh_q) < POOL_SIZE) begin
					take_fresh = ctl.exec;
					res.granted_handle = HANDLE_W'(fresh_q);
				end else begin
					res.status = ST_EXHAUSTED;
				end
			end
			CMD_TRY_ALLOCATE: begin
				if (!q_empty) begin
					pop = ctl.exec;
					res.granted_handle = rd_data;
				end else begin
					res.status = ST_NONE_TO_REUSE;
				end
			end
			CMD_DEALLOCATE: begin
				if (rel_ok) begin
					push = ctl.exec;
				end else begin
					res.status = ST_NOT_ALLOCATED;
				end
			end
			default: ;
		endcase
	end

	// request and result registers carry payload only
	always_ff @(posedge clk) begin
		if (ctl.load) begin
			req_q <= req;
		end
		if (ctl.exec) begin
			rsp_q <= res;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			head_q  <= '0;
			tail_q  <= '0;
			count_q <= '0;
			fresh_q <= '0;
			marks_q <= '0;
		end else begin
			if (pop) begin
				head_q  <= head_nxt;
				count_q <= count_q - 1'b1;
				marks_q[PTR_W'(rd_data)] <= 1'b1;
			end
			if (take_fresh) begin
				fresh_q <= fresh_q + 1'b1;
				marks_q[PTR_W'(fresh_q)] <= 1'b1;
			end
			if (push) begin
				tail_q  <= tail_nxt;
				count_q <= count_q + 1'b1;
				marks_q[rel_idx] <= 1'b0;
			end
		end
	end

	assign rsp = rsp_q;

endmodule

### hdl/handle_pool_allocator_top.sv
// ----------------------------------------------------------------------------
// handle_pool_allocator_top
// hands out handles from a fixed pool, reusing released handles oldest first
// ----------------------------------------------------------------------------
// one request is taken when start is high and busy is low; busy then stays
// high for exactly one cycle while the request executes, so a new request can
// be taken once busy drops. accept and execute are split because the free
// queue ram read is registered: the oldest released handle shows up the cycle
// after the head pointer settles. the result beat appears on rsp with done
// high for a single cycle, the cycle after the execute cycle, and overlaps
// the next accept; the receiver must take it then, it cannot hold it off.
// allocate reuses the oldest released handle or else issues the next fresh
// one, try_allocate only reuses, and deallocate queues an allocated handle.
// failures are reported in rsp.status with a zero handle and no state change.
// the allocation bitmap and all counters clear on reset; the free queue
// contents need no clearing since only written entries are ever read.
// ----------------------------------------------------------------------------
module handle_pool_allocator_top
	import hpa_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic start,
	output logic busy,
	input  req_t req,
	output logic done,
	output rsp_t rsp
);

	// command bundle from sequencer to datapath
	ctl_t ctl;

	hpa_ctrl u_ctrl (
		.clk   (clk),
		.arst_n(arst_n),
		.start (start),
		.busy  (busy),
		.done  (done),
		.ctl   (ctl)
	);

	hpa_dp u_dp (
		.clk   (clk),
		.arst_n(arst_n),
		.ctl   (ctl),
		.req   (req),
		.rsp   (rsp)
	);

	// execute lasts exactly one cycle
	a_exec_one_cycle: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> !busy)
		else $error("busy held for more than one cycle");

	// an accepted request executes in the next cycle
	a_accept_exec: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not execute");

	// every execute produces exactly one result beat right after it
	a_exec_done: assert property (@(posedge clk) disable iff (!arst_n)
		busy |=> done)
		else $error("execute without result beat");

	a_done_after_exec: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(busy))
		else $error("result beat without execute");

	// a failed request never hands out a handle
	a_fail_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(done && rsp.status != ST_OK) |-> (rsp.granted_handle == '0))
		else $error("failed request returned a handle");

endmodule
